// ===== src/tight_binding_dispersion_eval_assert.svh =====
// assertion macros for the tight-binding band evaluator
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef TIGHT_BINDING_DISPERSION_EVAL_ASSERT_SVH
`define TIGHT_BINDING_DISPERSION_EVAL_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked on every rising edge outside reset
`define TBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked on every rising edge, reset included
`define TBD_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define TBD_ASSERT(lbl, prop, msg)
`define TBD_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

// ===== src/tbd_pkg.sv =====
// shared types and constants of the tight-binding band evaluator
// no dependencies
`timescale 1ns / 1ps

package tbd_pkg;

  // default grid size and fixed field widths
  localparam int unsigned GRID_POINTS_DEF = 256;
  localparam int unsigned IDX_IN_W        = 8;
  localparam int unsigned FUNC_W          = 3;
  localparam int unsigned HOP_W           = 16;
  localparam int unsigned TRIG_W          = 16;
  localparam int unsigned VALUE_W         = 32;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned IN_TDATA_W      = 2 * IDX_IN_W;
  localparam int unsigned TRIG_PORTS      = 4;

  // result selector
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENERGY  = 3'd0,
    FUNC_GRAD_X  = 3'd1,
    FUNC_GRAD_Y  = 3'd2,
    FUNC_HESS_XX = 3'd3,
    FUNC_HESS_YY = 3'd4,
    FUNC_HESS_XY = 3'd5
  } func_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOP_SECOND = 2'd0,
    REG_HOP_THIRD  = 2'd1,
    REG_HOP_FOURTH = 2'd2
  } reg_e;

  // one table entry, cosine and sine in q2.14
  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } trig_t;

endpackage

// ===== src/tbd_trig_rom.sv =====
// cosine and sine table over the grid, q2.14 rounded to nearest
// four registered read ports; depends on tbd_pkg
`timescale 1ns / 1ps

module tbd_trig_rom #(
  parameter int unsigned GRID_POINTS = tbd_pkg::GRID_POINTS_DEF,
  parameter int unsigned IDX_W       = $clog2(GRID_POINTS)
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [IDX_W-1:0]      addr_i [tbd_pkg::TRIG_PORTS],
  output tbd_pkg::trig_t        data_o [tbd_pkg::TRIG_PORTS]
);
  import tbd_pkg::*;

  localparam real TWO_PI  = 6.283185307179586;
  localparam real Q14_ONE = 16384.0;

  // entry m holds cos and sin of 2*pi*m/grid, magnitude rounded half up
  function automatic trig_t trig_entry(input int unsigned m);
    real         ang;
    real         cv;
    real         sv;
    int unsigned cq;
    int unsigned sq;
    trig_t       e;
    ang = TWO_PI * real'(m) / GRID_POINTS;
    cv  = $cos(ang);
    sv  = $sin(ang);
    cq  = $rtoi(((cv < 0.0) ? -cv : cv) * Q14_ONE + 0.5);
    sq  = $rtoi(((sv < 0.0) ? -sv : sv) * Q14_ONE + 0.5);
    e.cos_v = (cv < 0.0) ? -TRIG_W'(cq) : TRIG_W'(cq);
    e.sin_v = (sv < 0.0) ? -TRIG_W'(sq) : TRIG_W'(sq);
    return e;
  endfunction

  trig_t rom_tbl [GRID_POINTS];
  trig_t data_q  [TRIG_PORTS];

  // constant table contents
  for (genvar g = 0; g < GRID_POINTS; g++) begin : g_tbl
    assign rom_tbl[g] = trig_entry(g);
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int p = 0; p < TRIG_PORTS; p++) begin
        data_q[p] <= rom_tbl[addr_i[p]];
      end
    end
  end

  assign data_o = data_q;

endmodule

// ===== src/tight_binding_dispersion_eval.sv =====
// Throughput: one request per clock while the output is not stalled; every stage holds
// one item, so the rate is set by the registered table read and the two multiplier
// ranks, each one stage deep.
// A stalled output holds the pipeline from the back; empty stages still fill.
// Reset clears the stage valid bits and the three hopping registers to zero.
// top level of the tight-binding band evaluator; depends on tbd_pkg,
// tbd_trig_rom and tight_binding_dispersion_eval_assert.svh
`timescale 1ns / 1ps
`include "tight_binding_dispersion_eval_assert.svh"

module tight_binding_dispersion_eval #(
  parameter int unsigned GRID_POINTS = tbd_pkg::GRID_POINTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [tbd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tbd_pkg::HOP_W-1:0]         cfg_wdata_i,
  // request side
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [tbd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // kx_index [7:0], ky_index [15:8]
  input  logic [tbd_pkg::FUNC_W-1:0]        s_axis_tuser,  // func [2:0]
  // result side
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tbd_pkg::VALUE_W-1:0]       m_axis_tdata,  // value [31:0]
  output logic [0:0]                        m_axis_tuser   // saturated [0]
);
  import tbd_pkg::*;

  localparam int unsigned IDX_W      = $clog2(GRID_POINTS);
  localparam int unsigned NUM_STAGES = 10;
  localparam int unsigned MOD_DEPTH  = 2 ** IDX_IN_W;
  localparam int unsigned A_W        = TRIG_W + 3;
  localparam int unsigned B_W        = TRIG_W + 3;
  localparam int unsigned PROD_W     = 2 * TRIG_W - 2;
  localparam int unsigned PN_W       = PROD_W + 1;
  localparam int unsigned QS_W       = PROD_W + 3;
  localparam int unsigned TP_W       = HOP_W + PN_W;
  localparam int unsigned TQ_W       = HOP_W + QS_W;
  localparam int unsigned TB_W       = HOP_W + B_W;
  localparam int unsigned SUM_W      = 52;
  localparam int unsigned FRAC_DROP  = 24;
  localparam int unsigned RND_W      = SUM_W - FRAC_DROP;
  localparam int unsigned A_SHIFT    = 26;
  localparam int unsigned B_SHIFT    = 14;

  localparam logic signed [SUM_W-1:0]   HALF    = SUM_W'(1) <<< (FRAC_DROP - 1);
  localparam logic signed [SUM_W-1:0]   HALF_M1 = HALF - SUM_W'(1);
  localparam logic signed [VALUE_W:0]   MAX_EXT = (VALUE_W+1)'((64'd1 << (VALUE_W-1)) - 64'd1);
  localparam logic signed [VALUE_W:0]   MIN_EXT = -MAX_EXT - (VALUE_W+1)'(1);
  localparam logic [VALUE_W-1:0]        VALUE_MAX = MAX_EXT[VALUE_W-1:0];
  localparam logic [VALUE_W-1:0]        VALUE_MIN = MIN_EXT[VALUE_W-1:0];

  // index doubled and wrapped to the grid
  function automatic logic [IDX_W-1:0] wrap_double(input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] dbl;
    dbl = {idx, 1'b0};
    if (dbl >= (IDX_W+1)'(GRID_POINTS)) dbl = dbl - (IDX_W+1)'(GRID_POINTS);
    return dbl[IDX_W-1:0];
  endfunction

  // hopping registers
  logic signed [HOP_W-1:0] hop_second_q, hop_third_q, hop_fourth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_second_q <= '0;
      hop_third_q  <= '0;
      hop_fourth_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HOP_SECOND: hop_second_q <= cfg_wdata_i;
        REG_HOP_THIRD:  hop_third_q  <= cfg_wdata_i;
        REG_HOP_FOURTH: hop_fourth_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage valid bits and per-stage enables, bubbles collapse
  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = ~vld_q[NUM_STAGES-1] | m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NUM_STAGES-1];

  // stage 1: indexes modulo grid and doubled indexes
  logic [IDX_W-1:0] mod_tbl [MOD_DEPTH];

  for (genvar g = 0; g < MOD_DEPTH; g++) begin : g_mod
    assign mod_tbl[g] = IDX_W'(g % GRID_POINTS);
  end

  logic [IDX_W-1:0]  kx_mod, ky_mod;
  logic [IDX_W-1:0]  s1_kx_q, s1_ky_q, s1_kx2_q, s1_ky2_q;
  logic [FUNC_W-1:0] s1_func_q;

  assign kx_mod = mod_tbl[s_axis_tdata[IDX_IN_W-1:0]];
  assign ky_mod = mod_tbl[s_axis_tdata[2*IDX_IN_W-1:IDX_IN_W]];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_kx_q   <= kx_mod;
      s1_ky_q   <= ky_mod;
      s1_kx2_q  <= wrap_double(kx_mod);
      s1_ky2_q  <= wrap_double(ky_mod);
      s1_func_q <= s_axis_tuser;
    end
  end

  // stage 2: table reads
  logic [IDX_W-1:0]  rom_addr [TRIG_PORTS];
  trig_t             rom_data [TRIG_PORTS];
  logic [FUNC_W-1:0] s2_func_q;

  assign rom_addr[0] = s1_kx_q;
  assign rom_addr[1] = s1_ky_q;
  assign rom_addr[2] = s1_kx2_q;
  assign rom_addr[3] = s1_ky2_q;

  tbd_trig_rom #(
    .GRID_POINTS (GRID_POINTS),
    .IDX_W       (IDX_W)
  ) u_trig_rom (
    .clk_i  (clk_i),
    .en_i   (en[1]),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  always_ff @(posedge clk_i) begin
    if (en[1]) s2_func_q <= s1_func_q;
  end

  // stage 3: operand selection per result kind
  logic signed [TRIG_W-1:0] cx, sx, cy, sy, c2x, s2x, c2y, s2y;

  assign cx  = rom_data[0].cos_v;
  assign sx  = rom_data[0].sin_v;
  assign cy  = rom_data[1].cos_v;
  assign sy  = rom_data[1].sin_v;
  assign c2x = rom_data[2].cos_v;
  assign s2x = rom_data[2].sin_v;
  assign c2y = rom_data[3].cos_v;
  assign s2y = rom_data[3].sin_v;

  logic signed [A_W-1:0]    a_d, s3_a_q;
  logic signed [B_W-1:0]    b_d, s3_b_q;
  logic signed [TRIG_W-1:0] pa_d, pb_d, q1a_d, q1b_d, q2a_d, q2b_d;
  logic signed [TRIG_W-1:0] s3_pa_q, s3_pb_q, s3_q1a_q, s3_q1b_q, s3_q2a_q, s3_q2b_q;
  logic [1:0]               k1_d, k2_d, s3_k1_q, s3_k2_q;
  logic                     pneg_d, qneg_d, s3_pneg_q, s3_qneg_q;

  always_comb begin
    a_d    = '0;
    b_d    = '0;
    pa_d   = '0;
    pb_d   = '0;
    q1a_d  = '0;
    q1b_d  = '0;
    q2a_d  = '0;
    q2b_d  = '0;
    k1_d   = 2'd0;
    k2_d   = 2'd0;
    pneg_d = 1'b0;
    qneg_d = 1'b0;
    case (s2_func_q)
      FUNC_ENERGY: begin
        a_d    = -((A_W'(cx) + A_W'(cy)) <<< 1);
        b_d    = -((B_W'(c2x) + B_W'(c2y)) <<< 1);
        pa_d   = cx;
        pb_d   = cy;
        pneg_d = 1'b1;
        q1a_d  = c2x;
        q1b_d  = cy;
        q2a_d  = c2y;
        q2b_d  = cx;
        qneg_d = 1'b1;
      end
      FUNC_GRAD_X: begin
        a_d   = A_W'(sx) <<< 1;
        b_d   = B_W'(s2x) <<< 2;
        pa_d  = sx;
        pb_d  = cy;
        q1a_d = s2x;
        q1b_d = cy;
        k1_d  = 2'd1;
        q2a_d = c2y;
        q2b_d = sx;
      end
      FUNC_GRAD_Y: begin
        a_d   = A_W'(sy) <<< 1;
        b_d   = B_W'(s2y) <<< 2;
        pa_d  = cx;
        pb_d  = sy;
        q1a_d = c2x;
        q1b_d = sy;
        q2a_d = s2y;
        q2b_d = cx;
        k2_d  = 2'd1;
      end
      FUNC_HESS_XX: begin
        a_d   = A_W'(cx) <<< 1;
        b_d   = B_W'(c2x) <<< 3;
        pa_d  = cx;
        pb_d  = cy;
        q1a_d = c2x;
        q1b_d = cy;
        k1_d  = 2'd2;
        q2a_d = c2y;
        q2b_d = cx;
      end
      FUNC_HESS_YY: begin
        a_d   = A_W'(cy) <<< 1;
        b_d   = B_W'(c2y) <<< 3;
        pa_d  = cx;
        pb_d  = cy;
        q1a_d = c2x;
        q1b_d = cy;
        q2a_d = c2y;
        q2b_d = cx;
        k2_d  = 2'd2;
      end
      FUNC_HESS_XY: begin
        pa_d   = sx;
        pb_d   = sy;
        pneg_d = 1'b1;
        q1a_d  = s2x;
        q1b_d  = sy;
        k1_d   = 2'd1;
        q2a_d  = s2y;
        q2b_d  = sx;
        k2_d   = 2'd1;
        qneg_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_a_q    <= a_d;
      s3_b_q    <= b_d;
      s3_pa_q   <= pa_d;
      s3_pb_q   <= pb_d;
      s3_q1a_q  <= q1a_d;
      s3_q1b_q  <= q1b_d;
      s3_q2a_q  <= q2a_d;
      s3_q2b_q  <= q2b_d;
      s3_k1_q   <= k1_d;
      s3_k2_q   <= k2_d;
      s3_pneg_q <= pneg_d;
      s3_qneg_q <= qneg_d;
    end
  end

  // stage 4: trig products
  logic signed [PROD_W-1:0] s4_p_q, s4_q1_q, s4_q2_q;
  logic signed [A_W-1:0]    s4_a_q;
  logic signed [B_W-1:0]    s4_b_q;
  logic [1:0]               s4_k1_q, s4_k2_q;
  logic                     s4_pneg_q, s4_qneg_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_p_q    <= PROD_W'(s3_pa_q) * PROD_W'(s3_pb_q);
      s4_q1_q   <= PROD_W'(s3_q1a_q) * PROD_W'(s3_q1b_q);
      s4_q2_q   <= PROD_W'(s3_q2a_q) * PROD_W'(s3_q2b_q);
      s4_a_q    <= s3_a_q;
      s4_b_q    <= s3_b_q;
      s4_k1_q   <= s3_k1_q;
      s4_k2_q   <= s3_k2_q;
      s4_pneg_q <= s3_pneg_q;
      s4_qneg_q <= s3_qneg_q;
    end
  end

  // stage 5: signs and weights of the products
  logic signed [QS_W-1:0] qs;
  logic signed [PN_W-1:0] s5_p_q;
  logic signed [QS_W-1:0] s5_q_q;
  logic signed [A_W-1:0]  s5_a_q;
  logic signed [B_W-1:0]  s5_b_q;

  assign qs = (QS_W'(s4_q1_q) <<< s4_k1_q) + (QS_W'(s4_q2_q) <<< s4_k2_q);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_p_q <= s4_pneg_q ? -PN_W'(s4_p_q) : PN_W'(s4_p_q);
      s5_q_q <= s4_qneg_q ? -qs : qs;
      s5_a_q <= s4_a_q;
      s5_b_q <= s4_b_q;
    end
  end

  // stage 6: hopping products
  logic signed [TP_W-1:0] s6_tp_q;
  logic signed [TQ_W-1:0] s6_tq_q;
  logic signed [TB_W-1:0] s6_tb_q;
  logic signed [A_W-1:0]  s6_a_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_tp_q <= TP_W'(hop_second_q) * TP_W'(s5_p_q);
      s6_tq_q <= TQ_W'(hop_fourth_q) * TQ_W'(s5_q_q);
      s6_tb_q <= TB_W'(hop_third_q) * TB_W'(s5_b_q);
      s6_a_q  <= s5_a_q;
    end
  end

  // stage 7: partial sums aligned to q12.40
  logic signed [SUM_W-1:0] s7_ab_q, s7_pq_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s7_ab_q <= (SUM_W'(s6_a_q) <<< A_SHIFT) + (SUM_W'(s6_tb_q) <<< B_SHIFT);
      s7_pq_q <= (SUM_W'(s6_tp_q) + SUM_W'(s6_tq_q)) <<< 2;
    end
  end

  // stage 8: full sum
  logic signed [SUM_W-1:0] s8_v_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) s8_v_q <= s7_ab_q + s7_pq_q;
  end

  // stage 9: round to q12.16, ties away from zero
  logic signed [SUM_W-1:0] rnd_full;
  logic signed [RND_W-1:0] s9_rnd_q;

  assign rnd_full = s8_v_q + (s8_v_q[SUM_W-1] ? HALF_M1 : HALF);

  always_ff @(posedge clk_i) begin
    if (en[8]) s9_rnd_q <= RND_W'(rnd_full >>> FRAC_DROP);
  end

  // stage 10: saturation and output register
  logic signed [VALUE_W:0]  rnd_ext;
  logic [VALUE_W-1:0]       s10_value_q;
  logic                     s10_sat_q;

  assign rnd_ext = (VALUE_W+1)'(s9_rnd_q);

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      if (rnd_ext > MAX_EXT) begin
        s10_value_q <= VALUE_MAX;
        s10_sat_q   <= 1'b1;
      end else if (rnd_ext < MIN_EXT) begin
        s10_value_q <= VALUE_MIN;
        s10_sat_q   <= 1'b1;
      end else begin
        s10_value_q <= rnd_ext[VALUE_W-1:0];
        s10_sat_q   <= 1'b0;
      end
    end
  end

  assign m_axis_tdata    = s10_value_q;
  assign m_axis_tuser[0] = s10_sat_q;

  // checks
  `TBD_ASSERT(a_item_count, $past(rst_ni) |-> ($countones(vld_q) == $past($countones(vld_q)) + $past(s_axis_tvalid && s_axis_tready) - $past(m_axis_tvalid && m_axis_tready)), "pipeline lost or repeated an item")
  `TBD_ASSERT(a_sat_extreme, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == VALUE_MAX || m_axis_tdata == VALUE_MIN), "saturated result not at a range limit")
  `TBD_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "request blocked with empty output stage")
  `TBD_ASSERT_NORST(a_reset_clear, !rst_ni |=> (vld_q == '0), "valid bits not cleared by reset")

endmodule
